>>> rtl/core/accel_tilt_pitch_roll_defines.svh
// Assertion macros shared by the accel_tilt_pitch_roll RTL.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef ACCEL_TILT_PITCH_ROLL_DEFINES_SVH
`define ACCEL_TILT_PITCH_ROLL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ATP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ATP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/atp_pkg.sv
// Package for accel_tilt_pitch_roll: widths, CORDIC angle table, register map, types.
// No dependencies.
package atp_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int TABLE_LEN       = 24;
    localparam int ACC_FRAC        = 30;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int LIM_W  = 15;
    localparam int PRJ_W  = IN_W + 2;
    localparam int CW     = PRJ_W + CORDIC_STAGES + 2;
    localparam int AW     = ACC_FRAC + 4;
    localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int IDX_W  = $clog2(TABLE_LEN);
    localparam int NS     = CORDIC_STAGES + 2;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_LIMIT = REG_IDX_W'(0);

    typedef logic signed [CW-1:0]    t_cw;
    typedef logic signed [AW-1:0]    t_acc;
    typedef logic signed [PRJ_W-1:0] t_prj;
    typedef logic signed [IN_W-1:0]  t_sample;
    typedef logic signed [OUT_W-1:0] t_angle;
    typedef logic [LIM_W-1:0]        t_limit;

    localparam t_acc HALF_PI_Q30 = AW'(64'sd1686629713);
    localparam t_acc RND_HALF    = AW'(64'sd1 <<< (RND_SH - 1));
    localparam t_limit LIMIT_RST =
        LIM_W'((64'd1686629713 + (64'd1 << (RND_SH - 1))) >> RND_SH);

    // atan(2^-i) in Q30, truncated
    localparam t_acc ATAN_Q30 [TABLE_LEN] = '{
        AW'(64'sd843314856), AW'(64'sd497837829), AW'(64'sd263043836),
        AW'(64'sd133525158), AW'(64'sd67021686),  AW'(64'sd33543515),
        AW'(64'sd16775850),  AW'(64'sd8388437),   AW'(64'sd4194282),
        AW'(64'sd2097149),   AW'(64'sd1048575),   AW'(64'sd524287),
        AW'(64'sd262143),    AW'(64'sd131071),    AW'(64'sd65535),
        AW'(64'sd32767),     AW'(64'sd16383),     AW'(64'sd8191),
        AW'(64'sd4095),      AW'(64'sd2047),      AW'(64'sd1023),
        AW'(64'sd511),       AW'(64'sd255),       AW'(64'sd127)
    };

    // one CORDIC vector in flight
    typedef struct packed {
        t_cw  x;
        t_cw  y;
        t_acc acc;
        logic zero;
    } t_vec;

    // both angles of one sample
    typedef struct packed {
        t_vec pitch;
        t_vec roll;
    } t_stg;

endpackage

>>> rtl/core/atp_if.sv
// Stream interfaces for accel_tilt_pitch_roll: sample requests in, angle requests out.
// Depends on atp_pkg.
interface atp_in_if;
    import atp_pkg::*;
    logic    valid;
    logic    ready;
    t_sample accel_x;
    t_sample accel_y;
    t_sample accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atp_out_if;
    import atp_pkg::*;
    logic   valid;
    logic   ready;
    t_angle pitch_angle;
    t_angle roll_angle;

    modport source (output valid, output pitch_angle, output roll_angle, input ready);
    modport sink   (input valid, input pitch_angle, input roll_angle, output ready);
endinterface

>>> rtl/core/atp_apb.sv
// APB configuration register file for accel_tilt_pitch_roll (angle_limit).
// Depends on atp_pkg.
module atp_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [atp_pkg::PADDR_W-1:0]   paddr,
    input  logic [atp_pkg::PDATA_W-1:0]   pwdata,
    output logic [atp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output atp_pkg::t_limit               o_limit
);
    import atp_pkg::*;

    t_limit                 r_limit;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (w_wr && (w_idx == REG_ANGLE_LIMIT)) begin
            r_limit <= pwdata[LIM_W-1:0];
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ANGLE_LIMIT: prdata = PDATA_W'(r_limit);
            default:         prdata = '0;
        endcase
    end

    assign o_limit = r_limit;
endmodule

>>> rtl/core/atp_prerot.sv
// First pipeline stage: project the sample onto the stick axes, scale, quarter-turn.
// Depends on atp_pkg.
module atp_prerot (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic              i_en,
    input  atp_pkg::t_sample  i_accel_x,
    input  atp_pkg::t_sample  i_accel_y,
    input  atp_pkg::t_sample  i_accel_z,
    output logic              o_vld,
    output atp_pkg::t_stg     o_stg
);
    import atp_pkg::*;

    logic r_vld;
    t_stg r_stg;
    t_stg n_stg;
    t_prj w_nx;
    t_prj w_ny;
    t_prj w_nz;

    // turn a vector with negative x into the right half plane
    function automatic t_vec prerot(t_prj py, t_prj px);
        t_vec v;
        t_cw  sx;
        t_cw  sy;
        sx     = CW'(px) <<< CORDIC_STAGES;
        sy     = CW'(py) <<< CORDIC_STAGES;
        v.zero = (px == '0) && (py == '0);
        if (sx < 0) begin
            if (sy >= 0) begin
                v.x   = sy;
                v.y   = -sx;
                v.acc = HALF_PI_Q30;
            end else begin
                v.x   = -sy;
                v.y   = sx;
                v.acc = -HALF_PI_Q30;
            end
        end else begin
            v.x   = sx;
            v.y   = sy;
            v.acc = '0;
        end
        return v;
    endfunction

    assign w_nx = -PRJ_W'(i_accel_x);
    assign w_ny = -PRJ_W'(i_accel_y);
    assign w_nz = -PRJ_W'(i_accel_z);

    always_comb begin
        n_stg.pitch = prerot(w_nz, w_nx);
        n_stg.roll  = prerot(w_ny, w_nx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_stg <= n_stg;
        end
    end

    assign o_vld = r_vld;
    assign o_stg = r_stg;
endmodule

>>> rtl/core/atp_cordic_stage.sv
// One registered CORDIC vectoring iteration, applied to the pitch and roll vectors.
// Depends on atp_pkg; the iteration index is tied to a constant by the parent.
module atp_cordic_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [atp_pkg::IDX_W-1:0]  i_idx,
    input  logic                       i_vld,
    input  logic                       i_en,
    input  atp_pkg::t_stg              i_stg,
    output logic                       o_vld,
    output atp_pkg::t_stg              o_stg
);
    import atp_pkg::*;

    logic r_vld;
    t_stg r_stg;
    t_stg n_stg;

    // step toward y = 0; shifts floor toward minus infinity
    function automatic t_vec step(t_vec v, logic [IDX_W-1:0] idx);
        t_vec r;
        t_cw  xs;
        t_cw  ys;
        xs     = v.x >>> idx;
        ys     = v.y >>> idx;
        r.zero = v.zero;
        if (!v.y[CW-1]) begin
            r.x   = v.x + ys;
            r.y   = v.y - xs;
            r.acc = v.acc + ATAN_Q30[idx];
        end else begin
            r.x   = v.x - ys;
            r.y   = v.y + xs;
            r.acc = v.acc - ATAN_Q30[idx];
        end
        return r;
    endfunction

    always_comb begin
        n_stg.pitch = step(i_stg.pitch, i_idx);
        n_stg.roll  = step(i_stg.roll, i_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_stg <= n_stg;
        end
    end

    assign o_vld = r_vld;
    assign o_stg = r_stg;
endmodule

>>> rtl/core/atp_round_clamp.sv
// Last pipeline stage: round the Q30 angles, clamp to the limit, hold the result.
// Depends on atp_pkg.
module atp_round_clamp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic              i_en,
    input  atp_pkg::t_stg     i_stg,
    input  atp_pkg::t_limit   i_limit,
    output logic              o_vld,
    output atp_pkg::t_angle   o_pitch,
    output atp_pkg::t_angle   o_roll
);
    import atp_pkg::*;

    logic   r_vld;
    t_angle r_pitch;
    t_angle r_roll;
    t_angle n_pitch;
    t_angle n_roll;
    t_acc   w_lim;

    // round half up, clamp symmetrically, force zero vector to zero
    function automatic t_angle round_clamp(t_vec v, t_acc lim);
        t_acc r;
        r = (v.acc + RND_HALF) >>> RND_SH;
        if (v.zero) begin
            r = '0;
        end
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r[OUT_W-1:0];
    endfunction

    assign w_lim = AW'(i_limit);

    always_comb begin
        n_pitch = round_clamp(i_stg.pitch, w_lim);
        n_roll  = round_clamp(i_stg.roll, w_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_pitch <= n_pitch;
            r_roll  <= n_roll;
        end
    end

    assign o_vld   = r_vld;
    assign o_pitch = r_pitch;
    assign o_roll  = r_roll;
endmodule

>>> rtl/core/accel_tilt_pitch_roll.sv
// accel_tilt_pitch_roll: top level of the stick tilt-angle pipeline.
// Depends on atp_pkg, atp_if, atp_apb, atp_prerot, atp_cordic_stage, atp_round_clamp.
`include "accel_tilt_pitch_roll_defines.svh"

// Each sample request (accel_x, accel_y, accel_z) yields one angle request with
// pitch = atan2(-z, -x) and roll = atan2(-y, -x), in radians with 13 fractional
// bits, each clamped to +/- angle_limit (APB register 0 at byte address 0, reset
// value pi/2). A zero vector gives 0. The pipeline takes one sample every cycle while
// no stall on the output side has backed up to its input. One stage projects and
// quarter-turns the vector, one stage per CORDIC iteration, one stage rounds and
// clamps into the output register. Every stage carries its own valid bit and loads
// whenever it is empty or its successor moves, so a stall on the output side only
// backs up as far as the pipeline is full and bubbles are squeezed out. Write the
// limit only while the pipeline is empty; it is sampled at the clamp stage.
module accel_tilt_pitch_roll (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    atp_in_if.sink                        i_in,
    atp_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [atp_pkg::PADDR_W-1:0]   paddr,
    input  logic [atp_pkg::PDATA_W-1:0]   pwdata,
    output logic [atp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import atp_pkg::*;

    logic                    w_vld [NS];
    logic                    w_en  [NS];
    t_stg                    w_stg [CORDIC_STAGES + 1];
    t_limit                  w_limit;
    logic signed [OUT_W:0]   w_lim_s;

    // configuration registers
    atp_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (w_limit)
    );

    // stage enables: a stage advances when it is empty or the next stage advances
    always_comb begin
        w_en[NS-1] = !w_vld[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !w_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    // projection and quarter-turn
    atp_prerot u_prerot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_in.valid),
        .i_en      (w_en[0]),
        .i_accel_x (i_in.accel_x),
        .i_accel_y (i_in.accel_y),
        .i_accel_z (i_in.accel_z),
        .o_vld     (w_vld[0]),
        .o_stg     (w_stg[0])
    );

    // one stage per CORDIC iteration
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        atp_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(k)),
            .i_vld   (w_vld[k]),
            .i_en    (w_en[k+1]),
            .i_stg   (w_stg[k]),
            .o_vld   (w_vld[k+1]),
            .o_stg   (w_stg[k+1])
        );
    end

    // round, clamp and hold the result request
    atp_round_clamp u_round_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[CORDIC_STAGES]),
        .i_en    (w_en[NS-1]),
        .i_stg   (w_stg[CORDIC_STAGES]),
        .i_limit (w_limit),
        .o_vld   (w_vld[NS-1]),
        .o_pitch (o_out.pitch_angle),
        .o_roll  (o_out.roll_angle)
    );

    assign o_out.valid = w_vld[NS-1];

    // checks: clamp honored, backpressure only with a full first stage, no drop
    assign w_lim_s = (OUT_W + 1)'(w_limit);

    `ATP_ASSERT_NOW(a_pitch_clamped, o_out.valid, (o_out.pitch_angle <= w_lim_s) && (o_out.pitch_angle >= -w_lim_s), "pitch outside angle limit")
    `ATP_ASSERT_NOW(a_roll_clamped, o_out.valid, (o_out.roll_angle <= w_lim_s) && (o_out.roll_angle >= -w_lim_s), "roll outside angle limit")
    `ATP_ASSERT_NOW(a_ready_low_full, !i_in.ready, w_vld[0], "input held off with empty first stage")
    `ATP_ASSERT_NEXT(a_hold_first, w_vld[0] && !w_en[1], w_vld[0], "held request lost in first stage")
endmodule

>>> test/tb_top.sv
// Self-checking bench for accel_tilt_pitch_roll: random and directed sample requests,
// APB limit writes, bit-exact prediction of the clamped CORDIC pitch and roll angles.
// Depends on atp_pkg, atp_if and the accel_tilt_pitch_roll RTL.
module tb_top;
    import atp_pkg::*;

    // Own copy of the angle arithmetic: Q30 accumulator, rounded to 13 fraction bits.
    localparam int      ITERATIONS  = 16;
    localparam int      Q30_TO_OUT  = 17;
    localparam longint  QUARTER_Q30 = 64'sd1686629713;
    localparam longint  ARCTAN_Q30 [ITERATIONS] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
    };
    localparam logic [14:0] LIMIT_AT_RESET = 15'd12868;
    localparam logic [14:0] LIMIT_MAX      = 15'd25736;

    // Register map: the limit at byte address 0; the next word is unmapped.
    localparam logic [PADDR_W-1:0] LIMIT_ADDR    = PADDR_W'(4 * REG_ANGLE_LIMIT);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);

    localparam int PIPE_DEPTH  = NS;        // pipeline stages as listed at the head of the top level
    localparam int SETTLE      = PIPE_DEPTH + 4;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_sample ax;
        t_sample ay;
        t_sample az;
    } accel_req_t;

    typedef struct {
        t_angle pitch;
        t_angle roll;
    } tilt_req_t;

    typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    atp_in_if  samp_if ();
    atp_out_if tilt_if ();

    accel_req_t sample_pending [$];   // sample requests not yet offered
    tilt_req_t  tilt_expected [$];    // angle pairs owed by the block, oldest first
    logic [14:0] tilt_limit;          // bench copy of the clamp register
    int          err_cnt;
    int          hold_reqs;           // bumped to ask the receiver for a long hold-off

    accel_tilt_pitch_roll u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (samp_if),
        .o_out   (tilt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("accel_tilt_pitch_roll verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // atan2(num, den) by vectoring CORDIC; the zero vector gives 0.
    function automatic longint fixed_atan2(longint num, longint den);
        longint xv, yv, acc, xs, ys, t;
        int     i;
        if (num == 0 && den == 0)
            return 0;
        xv  = den <<< ITERATIONS;
        yv  = num <<< ITERATIONS;
        acc = 0;
        // Quarter-turn a left-half vector into the right half first.
        if (xv < 0) begin
            if (yv >= 0) begin
                t = xv; xv = yv; yv = -t; acc = QUARTER_Q30;
            end else begin
                t = xv; xv = -yv; yv = t; acc = -QUARTER_Q30;
            end
        end
        for (i = 0; i < ITERATIONS; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv += ys; yv -= xs; acc += ARCTAN_Q30[i];
            end else begin
                xv -= ys; yv += xs; acc -= ARCTAN_Q30[i];
            end
        end
        // Round half up, shifting toward minus infinity.
        return (acc + (64'sd1 <<< (Q30_TO_OUT - 1))) >>> Q30_TO_OUT;
    endfunction

    function automatic t_angle clamp_angle(longint a, logic [14:0] lim);
        longint l;
        l = longint'({49'd0, lim});
        if (a > l)  a = l;
        if (a < -l) a = -l;
        return t_angle'(a);
    endfunction

    // Stick axis is -x; pitch leans toward -z, roll toward -y.
    function automatic tilt_req_t predict_tilt(accel_req_t s, logic [14:0] lim);
        tilt_req_t r;
        longint    stick;
        stick   = -longint'(s.ax);
        r.pitch = clamp_angle(fixed_atan2(-longint'(s.az), stick), lim);
        r.roll  = clamp_angle(fixed_atan2(-longint'(s.ay), stick), lim);
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Sample driver: bursts of requests separated by random gaps. Hold
    // valid and the payload until the block takes the request.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        accel_req_t nxt;
        logic       nxt_valid;
        if (!i_rst_n) begin
            samp_if.valid <= 1'b0;
            burst_left    = 0;
            gap_left      = 0;
        end else begin
            nxt_valid = samp_if.valid;
            if (samp_if.valid && samp_if.ready) begin
                nxt.ax = samp_if.accel_x;
                nxt.ay = samp_if.accel_y;
                nxt.az = samp_if.accel_z;
                tilt_expected.push_back(predict_tilt(nxt, tilt_limit));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_pending.size() > 0) begin
                    nxt = sample_pending.pop_front();
                    samp_if.accel_x <= nxt.ax;
                    samp_if.accel_y <= nxt.ay;
                    samp_if.accel_z <= nxt.az;
                    nxt_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    // Burst over: pick the next gap and burst, sometimes a long clean run.
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 4) == 0) begin
                            burst_left = $urandom_range(40, 120);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(0, 6);
                        end
                    end
                end
            end
            samp_if.valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a stall mode that changes every so often,
    // and drops for a long stretch whenever a hold-off is asked for.
    // ------------------------------------------------------------------
    int       hold_done;
    int       hold_left;
    int       mode_left;
    int       rx_tick;
    rx_mode_e rx_mode;

    always @(posedge i_clk) begin
        logic nxt_ready;
        if (!i_rst_n) begin
            tilt_if.ready <= 1'b0;
            hold_done = 0;
            hold_left = 0;
            mode_left = 0;
            rx_tick   = 0;
            rx_mode   = RX_FREE;
        end else begin
            rx_tick++;
            if (hold_done != hold_reqs) begin
                hold_done = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:     nxt_ready = 1'b1;
                    RX_COIN:     nxt_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE:   nxt_ready = ($urandom_range(0, 3) != 0);
                    default:     nxt_ready = ((rx_tick % 7) < 3);
                endcase
            end
            tilt_if.ready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each angle request with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tilt_req_t want;
        if (i_rst_n && tilt_if.valid && tilt_if.ready) begin
            if (tilt_expected.size() == 0) begin
                note_mismatch($sformatf("angle request pitch=%0d roll=%0d with none owed",
                                        tilt_if.pitch_angle, tilt_if.roll_angle));
            end else begin
                want = tilt_expected.pop_front();
                if (tilt_if.pitch_angle !== want.pitch || tilt_if.roll_angle !== want.roll)
                    note_mismatch($sformatf("pitch got %0d want %0d, roll got %0d want %0d",
                                            tilt_if.pitch_angle, want.pitch,
                                            tilt_if.roll_angle, want.roll));
            end
        end
    end

    // ------------------------------------------------------------------
    // APB access: setup cycle, then access cycle until pready.
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, track it, then read the limit back and check it.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, addr, val, rd);
        if (addr == LIMIT_ADDR)
            tilt_limit = val[14:0];
        apb_access(1'b0, LIMIT_ADDR, '0, rd);
        if (rd !== PDATA_W'(tilt_limit))
            note_mismatch($sformatf("limit read %0d want %0d", rd, tilt_limit));
    endtask

    // Idle until every offered request has come back, then let the pipe settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_pending.size() != 0 || samp_if.valid || tilt_expected.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic t_sample pick_field();
        case ($urandom_range(0, 9))
            0, 1:    return t_sample'($urandom_range(0, 8) - 4);
            2: begin
                case ($urandom_range(0, 5))
                    0:       return -16'sd32768;
                    1:       return -16'sd32767;
                    2:       return -16'sd1;
                    3:       return 16'sd0;
                    4:       return 16'sd1;
                    default: return 16'sd32767;
                endcase
            end
            3:       return 16'sd0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        accel_req_t s;
        repeat (n) begin
            s.ax = pick_field();
            s.ay = pick_field();
            s.az = pick_field();
            sample_pending.push_back(s);
        end
    endtask

    task automatic queue_sample(int ax, int ay, int az);
        accel_req_t s;
        s.ax = t_sample'(ax);
        s.ay = t_sample'(ay);
        s.az = t_sample'(az);
        sample_pending.push_back(s);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases; the limit only moves while the pipe is empty.
    // ------------------------------------------------------------------
    initial begin
        logic [PDATA_W-1:0] rd;
        int                 guard;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        samp_if.valid   = 1'b0;
        samp_if.accel_x = '0;
        samp_if.accel_y = '0;
        samp_if.accel_z = '0;
        tilt_if.ready   = 1'b0;
        tilt_limit      = LIMIT_AT_RESET;
        err_cnt         = 0;
        hold_reqs       = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Limit must come out of reset at pi/2.
        apb_access(1'b0, LIMIT_ADDR, '0, rd);
        if (rd !== PDATA_W'(tilt_limit))
            note_mismatch($sformatf("limit after reset %0d want %0d", rd, tilt_limit));

        // Directed: extremes, zero vector, zero stick, reversed stick on the axis.
        queue_sample(0, 0, 0);
        queue_sample(-32768, -32768, -32768);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, 32767, 32767);
        queue_sample(32767, -32768, -32768);
        queue_sample(5, 0, 0);
        queue_sample(32767, 0, 0);
        queue_sample(-1, 0, 0);
        queue_sample(-32768, 0, 0);
        queue_sample(0, 1, -1);
        queue_sample(0, -32768, 32767);
        queue_sample(0, 0, 1);
        queue_sample(0, 1, 0);
        queue_sample(1, -1, 1);
        queue_sample(-1, 1, -1);
        queue_sample(100, -3, 3);
        queue_sample(-20000, 12345, -23456);
        queue_sample(16384, -1, 1);
        queue_random(40);
        wait_drained();

        // Zero limit forces both angles to zero.
        write_reg(LIMIT_ADDR, 32'd0);
        queue_random(60);
        wait_drained();

        // Widest limit; receiver holds off so the pipe fills and backs up the input.
        write_reg(LIMIT_ADDR, PDATA_W'(LIMIT_MAX));
        queue_random(80);
        hold_reqs++;
        wait_drained();

        write_reg(LIMIT_ADDR, 32'd1);
        queue_random(60);
        wait_drained();

        // Unmapped word: the write must not touch the limit.
        write_reg(UNMAPPED_ADDR, 32'h0000_1234);
        queue_random(60);
        wait_drained();

        // Drop bits above the 15-bit field.
        write_reg(LIMIT_ADDR, 32'hFFFF_8000 | 32'd6434);
        queue_random(60);
        wait_drained();

        repeat (2) begin
            write_reg(LIMIT_ADDR, PDATA_W'($urandom_range(0, LIMIT_MAX)));
            queue_random(40);
            wait_drained();
        end

        write_reg(LIMIT_ADDR, PDATA_W'($urandom_range(0, LIMIT_MAX)));
        queue_random(40);

        // Drain with a bound, then give stray results a chance to show up.
        guard = 0;
        while (guard < 50000 &&
               (sample_pending.size() != 0 || samp_if.valid || tilt_expected.size() != 0)) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(negedge i_clk);
        if (tilt_expected.size() != 0)
            note_mismatch($sformatf("%0d angle requests never arrived", tilt_expected.size()));

        if (err_cnt == 0)
            $display("accel_tilt_pitch_roll verification clean");
        else
            $display("accel_tilt_pitch_roll verification failed");
        $finish;
    end

endmodule
